### rtl/stsm_pkg.sv
// Shared types and constants for the steepest tangent slope map.
// Used by the divider cell, the square-root cell and the top level.
package stsm_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int PIX_W      = 8;
   localparam int CNT_W      = 7;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int NUM_W      = 2 * PIX_W;
   localparam int DEN_W      = 2 * ROW_W + 1;
   localparam int PROD_W     = NUM_W + DEN_W;
   localparam int FRAC_BITS  = 32;
   localparam int QUO_W      = NUM_W + FRAC_BITS;
   localparam int ROOT_W     = QUO_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_SCAN,
      ST_FLUSH,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [QUO_W-1:0]  dq;
      logic [DEN_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
   } div_token_type;

   typedef struct packed {
      logic              valid;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [QUO_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [SREM_W-1:0] rem;
   } sqrt_token_type;

endpackage

### rtl/stsm_div_cell.sv
// One restoring division step: yields one quotient bit per cell.
// Depends on stsm_pkg.
module stsm_div_cell
   import stsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_token_type tok_i,
   output div_token_type tok_o
);

   div_token_type  tok_ff;
   div_token_type  tok_in;
   logic [DEN_W:0] r2;
   logic           ge;
   logic [DEN_W:0] diff;

   always_comb begin
      r2     = {tok_i.rem, tok_i.dq[QUO_W-1]};
      ge     = r2 >= {1'b0, tok_i.den};
      diff   = r2 - {1'b0, tok_i.den};
      tok_in = tok_i;
      tok_in.rem = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      tok_in.dq  = {tok_i.dq[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

### rtl/stsm_sqrt_cell.sv
// One restoring square-root step: yields one root bit per cell.
// Depends on stsm_pkg.
module stsm_sqrt_cell
   import stsm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  sqrt_token_type tok_i,
   output sqrt_token_type tok_o
);

   sqrt_token_type  tok_ff;
   sqrt_token_type  tok_in;
   logic [SREM_W+1:0] r4;
   logic [SREM_W+1:0] trial;
   logic              ge;
   logic [SREM_W+1:0] diff;

   always_comb begin
      r4     = {tok_i.rem, tok_i.rad[QUO_W-1 -: 2]};
      trial  = {2'b00, tok_i.root, 2'b01};
      ge     = r4 >= trial;
      diff   = r4 - trial;
      tok_in = tok_i;
      tok_in.rem  = ge ? diff[SREM_W-1:0] : r4[SREM_W-1:0];
      tok_in.root = {tok_i.root[ROOT_W-2:0], ge};
      tok_in.rad  = {tok_i.rad[QUO_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

### rtl/steepest_tangent_slope_map.sv
// Steepest tangent slope map: a load writes one pixel of a 64x64 grey image; a query scans the
// configured image one pixel per cycle and returns the steepest slope from the named pixel.
// A query inside the image first fetches the centre pixel, then scans every pixel in use (row_count
// times col_count, each clamped to 64), with the scan rate set by the single read port of the image
// memory; it then flushes the compare pipeline and passes the best slope through the 48-cell
// divider chain and the 24-cell square-root chain before the response shows. A query outside the
// image skips fetch and scan. One query is in flight at a time.
// Depends on stsm_pkg, stsm_div_cell and stsm_sqrt_cell.
module steepest_tangent_slope_map
   import stsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // row, col, pixel_value
   input  logic                 req_tuser,   // opcode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // slope, out_row, out_col
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] row_count_ff, col_count_ff, nr, nc;
   logic [ROW_W-1:0] req_row, q_row_ff, sr_ff, p_r_ff;
   logic [COL_W-1:0] req_col, q_col_ff, sc_ff, p_c_ff;
   logic [PIX_W-1:0] req_pix, centre_ff, rd_data_ff;
   logic [PIX_W-1:0] mem [STORE_DEPTH];
   logic [ADDR_W-1:0] rd_addr;
   logic req_acc, load_acc, query_acc, in_range, scan_last;
   logic p_valid_ff, c_valid_ff, c_valid_in;
   logic [NUM_W-1:0] c_num_ff, c_num_in, best_num_ff;
   logic [DEN_W-1:0] c_den_ff, c_den_in, best_den_ff;
   logic [PIX_W-1:0] d;
   logic [ROW_W-1:0] dr;
   logic [COL_W-1:0] dc;
   logic [PROD_W-1:0] lhs, rhs;
   logic launch_ff, launch_in;
   logic rsp_valid_ff;
   logic [ROOT_W-1:0] rsp_slope_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;

   div_token_type  div_tok  [DIV_STEPS+1];
   sqrt_token_type sqrt_tok [SQRT_STEPS+1];

   assign req_row   = req_tdata[ROW_W-1:0];
   assign req_col   = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_pix   = req_tdata[ROW_W+COL_W+PIX_W-1:ROW_W+COL_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc   = req_tvalid && req_tready;
   assign load_acc  = req_acc && (req_tuser == OP_LOAD);
   assign query_acc = req_acc && (req_tuser == OP_QUERY);
   assign csr_ready = 1'b1;

   assign nr = (row_count_ff > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_ff;
   assign nc = (col_count_ff > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_count_ff;
   assign in_range  = ({1'b0, req_row} < nr) && ({1'b0, req_col} < nc);
   assign scan_last = ({1'b0, sr_ff} == nr - 1'b1) && ({1'b0, sc_ff} == nc - 1'b1);
   assign rd_addr   = (state_ff == ST_IDLE) ? {req_row, req_col} : {sr_ff, sc_ff};

   always_ff @(posedge clock) begin
      if (load_acc) begin
         mem[{req_row, req_col}] <= req_pix;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CNT_W'(MAX_ROWS);
         col_count_ff <= CNT_W'(MAX_COLS);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_count_ff <= csr_data;
         end else if (csr_index == CSR_COL_COUNT) begin
            col_count_ff <= csr_data;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_acc) begin
               state_in = in_range ? ST_CENTRE : ST_FLUSH;
            end
         end
         ST_CENTRE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!p_valid_ff && !c_valid_ff) begin
               launch_in = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sqrt_tok[SQRT_STEPS].valid) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
      end
   end

   always_comb begin
      d  = (rd_data_ff > centre_ff) ? rd_data_ff - centre_ff : centre_ff - rd_data_ff;
      dr = (p_r_ff > q_row_ff) ? p_r_ff - q_row_ff : q_row_ff - p_r_ff;
      dc = (p_c_ff > q_col_ff) ? p_c_ff - q_col_ff : q_col_ff - p_c_ff;
      c_num_in = NUM_W'(d) * NUM_W'(d);
      c_den_in = DEN_W'(DEN_W'(dr) * DEN_W'(dr)) + DEN_W'(DEN_W'(dc) * DEN_W'(dc));
      c_valid_in = p_valid_ff && (rd_data_ff != centre_ff) && (c_den_in != '0);
      lhs = PROD_W'(c_num_ff) * PROD_W'(best_den_ff);
      rhs = PROD_W'(best_num_ff) * PROD_W'(c_den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         best_num_ff <= '0;
         best_den_ff <= DEN_W'(1);
         sr_ff       <= '0;
         sc_ff       <= '0;
      end else begin
         p_valid_ff <= (state_ff == ST_SCAN);
         c_valid_ff <= c_valid_in;
         p_r_ff     <= sr_ff;
         p_c_ff     <= sc_ff;
         c_num_ff   <= c_num_in;
         c_den_ff   <= c_den_in;
         if (query_acc) begin
            q_row_ff    <= req_row;
            q_col_ff    <= req_col;
            best_num_ff <= '0;
            best_den_ff <= DEN_W'(1);
            sr_ff       <= '0;
            sc_ff       <= '0;
         end else if (c_valid_ff && (lhs > rhs)) begin
            best_num_ff <= c_num_ff;
            best_den_ff <= c_den_ff;
         end
         if (state_ff == ST_CENTRE) begin
            centre_ff <= rd_data_ff;
         end
         if (state_ff == ST_SCAN) begin
            if ({1'b0, sc_ff} == nc - 1'b1) begin
               sc_ff <= '0;
               sr_ff <= sr_ff + 1'b1;
            end else begin
               sc_ff <= sc_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      div_tok[0].valid = launch_ff;
      div_tok[0].row   = q_row_ff;
      div_tok[0].col   = q_col_ff;
      div_tok[0].dq    = {best_num_ff, {FRAC_BITS{1'b0}}};
      div_tok[0].rem   = '0;
      div_tok[0].den   = best_den_ff;
      sqrt_tok[0].valid = div_tok[DIV_STEPS].valid;
      sqrt_tok[0].row   = div_tok[DIV_STEPS].row;
      sqrt_tok[0].col   = div_tok[DIV_STEPS].col;
      sqrt_tok[0].rad   = div_tok[DIV_STEPS].dq;
      sqrt_tok[0].root  = '0;
      sqrt_tok[0].rem   = '0;
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      stsm_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (div_tok[i]),
         .tok_o (div_tok[i+1])
      );
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      stsm_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (sqrt_tok[j]),
         .tok_o (sqrt_tok[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sqrt_tok[SQRT_STEPS].valid) begin
         rsp_valid_ff <= 1'b1;
         rsp_slope_ff <= sqrt_tok[SQRT_STEPS].root;
         rsp_row_ff   <= sqrt_tok[SQRT_STEPS].row;
         rsp_col_ff   <= sqrt_tok[SQRT_STEPS].col;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_col_ff, rsp_row_ff, rsp_slope_ff};

   a_rsp_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == ST_OUT))
      else $error("response shown outside output state");

   a_scan_pending: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_FLUSH))
      else $error("pixel read pending outside scan");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      best_den_ff != '0)
      else $error("best slope denominator is zero");

   a_launch_once: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff == ST_WAIT))
      else $error("divider launched outside wait state");

endmodule

### tb/tb_steepest_tangent_slope_map.sv
// Self-checking testbench for steepest_tangent_slope_map: fills the image corner in use, runs a
// directed table and random load/query traffic over several image sizes and idling phases.
// Depends on stsm_pkg and the steepest_tangent_slope_map RTL.
`timescale 1ns / 1ps

module tb_steepest_tangent_slope_map;
   import stsm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int SETTLE_CYCLES = 200;
   localparam int FILL_ROWS = 6;
   localparam int FILL_COLS = 6;

   typedef struct {
      logic [23:0]      slope;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } slope_result_type;

   typedef struct {
      logic             op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pix;
      bit               known;
      logic [23:0]      slope;
   } pixel_op_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CNT_W-1:0]     csr_data = '0;

   logic [PIX_W-1:0]  image_copy [STORE_DEPTH];
   int unsigned       rows_used = 64;
   int unsigned       cols_used = 64;
   slope_result_type  pending_slopes[$];
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                mismatches = 0;
   int                loads_sent = 0;
   int                queries_sent = 0;
   int                slopes_seen = 0;
   int                csr_writes = 0;
   bit                failed = 0;

   steepest_tangent_slope_map dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("timeout: %0d slopes still outstanding", pending_slopes.size());
      $display("== FAIL ==");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic logic [23:0] steepest_slope(int r0, int c0);
      longint unsigned best_num, best_den, d, dr, dc, num, den;
      int nr, nc, centre, v;
      best_num = 0;
      best_den = 1;
      nr = (rows_used > MAX_ROWS) ? MAX_ROWS : int'(rows_used);
      nc = (cols_used > MAX_COLS) ? MAX_COLS : int'(cols_used);
      if (r0 >= nr || c0 >= nc) return '0;
      centre = int'(image_copy[ADDR_W'(r0 * MAX_COLS + c0)]);
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            v = int'(image_copy[ADDR_W'(r * MAX_COLS + c)]);
            if (v == centre) continue;
            d   = 64'((v > centre) ? v - centre : centre - v);
            dr  = 64'((r > r0) ? r - r0 : r0 - r);
            dc  = 64'((c > c0) ? c - c0 : c0 - c);
            num = d * d;
            den = dr * dr + dc * dc;
            if (den == 0) continue;
            if (num * best_den > best_num * den) begin
               best_num = num;
               best_den = den;
            end
         end
      end
      return 24'(floor_sqrt((best_num << 32) / best_den));
   endfunction

   // call at a falling edge; returns at a falling edge with tvalid still high
   task automatic send_pixel_op(pixel_op_type item);
      slope_result_type expd;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.op;
      req_tdata  <= {4'b0, item.pix, item.col, item.row};
      do @(posedge clock); while (!req_tready);
      if (item.op == OP_LOAD) begin
         image_copy[{item.row, item.col}] = item.pix;
         loads_sent++;
      end else begin
         expd.slope = steepest_slope(int'(item.row), int'(item.col));
         expd.row   = item.row;
         expd.col   = item.col;
         if (item.known && expd.slope !== item.slope) begin
            $display("table row disagrees: (%0d,%0d) typed %0d predicted %0d",
                     item.row, item.col, item.slope, expd.slope);
            failed = 1;
         end
         if (item.known) expd.slope = item.slope;
         pending_slopes.push_back(expd);
         queries_sent++;
      end
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (pending_slopes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ROW_COUNT) rows_used = 32'(value);
      else if (idx == CSR_COL_COUNT) cols_used = 32'(value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic fill_image(bit randomise);
      pixel_op_type item;
      for (int a = 0; a < FILL_ROWS * FILL_COLS; a++) begin
         item.op    = OP_LOAD;
         item.row   = ROW_W'(a / FILL_COLS);
         item.col   = COL_W'(a % FILL_COLS);
         item.pix   = randomise ? PIX_W'($urandom_range(255)) : '0;
         item.known = 0;
         item.slope = '0;
         send_pixel_op(item);
      end
   endtask

   always @(posedge clock) begin
      slope_result_type expd, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slope = rsp_tdata[23:0];
         got.row   = rsp_tdata[29:24];
         got.col   = rsp_tdata[35:30];
         slopes_seen++;
         if (pending_slopes.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected slope %0d at (%0d,%0d)", got.slope, got.row, got.col);
         end else begin
            expd = pending_slopes.pop_front();
            if (got.slope !== expd.slope || got.row !== expd.row || got.col !== expd.col)
            begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected slope %0d (%0d,%0d), got %0d (%0d,%0d)",
                           expd.slope, expd.row, expd.col, got.slope, got.row, got.col);
            end
         end
      end
   end

   pixel_op_type directed_ops [] = '{
      '{OP_QUERY, 6'd0,  6'd0,  8'hAB,  1'b1, 24'd0},
      '{OP_LOAD,  6'd0,  6'd1,  8'd255, 1'b0, 24'd0},
      '{OP_QUERY, 6'd0,  6'd0,  8'd0,   1'b1, 24'hFF0000},
      '{OP_QUERY, 6'd0,  6'd1,  8'd0,   1'b1, 24'hFF0000},
      '{OP_LOAD,  6'd5,  6'd5,  8'd128, 1'b0, 24'd0},
      '{OP_QUERY, 6'd5,  6'd5,  8'hFF,  1'b0, 24'd0},
      '{OP_QUERY, 6'd5,  6'd0,  8'd0,   1'b0, 24'd0},
      '{OP_LOAD,  6'd2,  6'd2,  8'd1,   1'b0, 24'd0},
      '{OP_QUERY, 6'd2,  6'd1,  8'd0,   1'b0, 24'd0},
      '{OP_LOAD,  6'd0,  6'd1,  8'd0,   1'b0, 24'd0},
      '{OP_LOAD,  6'd5,  6'd5,  8'd0,   1'b0, 24'd0},
      '{OP_LOAD,  6'd2,  6'd2,  8'd0,   1'b0, 24'd0},
      '{OP_QUERY, 6'd63, 6'd63, 8'd0,   1'b1, 24'd0},
      '{OP_QUERY, 6'd3,  6'd4,  8'd0,   1'b1, 24'd0}
   };

   int size_rows [] = '{1, 1, 6, 3, 0, 127, 6, 5};
   int size_cols [] = '{1, 6, 1, 5, 7, 0, 6, 4};

   initial begin
      pixel_op_type item;
      int area, nr, nc;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(CSR_ROW_COUNT, CNT_W'(FILL_ROWS));
      write_csr(CSR_COL_COUNT, CNT_W'(FILL_COLS));
      fill_image(0);
      foreach (directed_ops[i]) send_pixel_op(directed_ops[i]);
      drain_and_settle();
      fill_image(1);

      foreach (size_rows[p]) begin
         if (p == 4) begin
            write_csr(CSR_SPARE_A, CNT_W'($urandom_range(127)));
            write_csr(CSR_SPARE_B, CNT_W'($urandom_range(127)));
         end
         write_csr(CSR_ROW_COUNT, CNT_W'(size_rows[p]));
         write_csr(CSR_COL_COUNT, CNT_W'(size_cols[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 74; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 74; end
            default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
         endcase
         nr = (rows_used > MAX_ROWS) ? MAX_ROWS : int'(rows_used);
         nc = (cols_used > MAX_COLS) ? MAX_COLS : int'(cols_used);
         area = nr * nc;
         for (int k = 0; k < 7; k++) begin
            item.known = 0;
            item.slope = '0;
            item.pix   = PIX_W'($urandom_range(255));
            item.op    = ($urandom_range(99) < ((area > 1024) ? 12 : 45)) ? OP_QUERY : OP_LOAD;
            if (nr > 0 && nc > 0 && $urandom_range(9) < 7) begin
               item.row = ROW_W'($urandom_range(nr - 1));
               item.col = COL_W'($urandom_range(nc - 1));
            end else begin
               item.row = ROW_W'($urandom_range(63));
               item.col = COL_W'($urandom_range(63));
            end
            send_pixel_op(item);
         end
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drain_and_settle();
      if (pending_slopes.size() != 0) failed = 1;
      $display("covered %0d loads, %0d queries, %0d register writes over %0d image sizes",
               loads_sent, queries_sent, csr_writes, size_rows.size());
      $display("slopes checked %0d, mismatches %0d", slopes_seen, mismatches);
      if (!failed)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
rtl/stsm_pkg.sv
rtl/stsm_div_cell.sv
rtl/stsm_sqrt_cell.sv
rtl/steepest_tangent_slope_map.sv
tb/tb_steepest_tangent_slope_map.sv
